>>> src/bed_pkg.sv
// Shared types and constants for the backslash escape decoder.
`default_nettype none

package bed_pkg;

    typedef enum logic [1:0] {
        REQ_TEXT    = 2'd0,
        REQ_ARG_END = 2'd1,
        REQ_CMD_END = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    localparam int unsigned REG_ESCAPE_ENABLE    = 0;
    localparam int unsigned REG_TRAILING_NEWLINE = 1;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       last;
        logic       command_done;
    } result_t;

    // up to two results per transaction, first is always queued ahead of second
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } dec_out_t;

endpackage : bed_pkg

`default_nettype wire

>>> src/bed_decoder.sv
// Escape decode state and per-transaction result generation.
`default_nettype none

module bed_decoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [1:0]        req_type,
    input  wire logic [7:0]        char_in,
    input  wire logic              escape_enable,
    input  wire logic              trailing_newline,
    output bed_pkg::dec_out_t      dec
);
    import bed_pkg::*;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_C         = 8'h63;
    localparam logic [7:0] CH_X         = 8'h78;

    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_BSL   = 4'b0010,
        MODE_OCT   = 4'b0100,
        MODE_HEX   = 4'b1000
    } mode_t;

    // {hit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // {hit, code} for the named control escapes
    function automatic logic [8:0] named_escape(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        unique case (c)
            8'h6E:   r = {1'b1, 8'h0A};
            8'h74:   r = {1'b1, 8'h09};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h61:   r = {1'b1, 8'h07};
            8'h62:   r = {1'b1, 8'h08};
            8'h65:   r = {1'b1, CH_ESC};
            8'h66:   r = {1'b1, 8'h0C};
            8'h72:   r = {1'b1, 8'h0D};
            8'h76:   r = {1'b1, 8'h0B};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    mode_t      mode_reg, mode_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] val_reg, val_next;
    logic       space_reg, space_next;
    logic       stop_reg, stop_next;

    logic [7:0] pb [2];
    logic [1:0] n;
    logic       done_f;
    logic       no_byte;
    logic [7:0] flush_byte;
    logic       flush_due;
    logic [4:0] hex;
    logic [8:0] code;
    logic [7:0] oct_val;
    logic [7:0] hex_val;
    logic [1:0] cnt_inc;
    logic       is_oct;

    always_comb
    begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        space_next = space_reg;
        stop_next  = stop_reg;
        n          = 2'd0;
        pb[0]      = 8'd0;
        pb[1]      = 8'd0;
        done_f     = 1'b0;
        no_byte    = 1'b0;
        flush_due  = (mode_reg != MODE_PLAIN);
        flush_byte = (mode_reg == MODE_BSL) ? CH_BACKSLASH : val_reg;
        hex        = hex_digit(char_in);
        code       = named_escape(char_in);
        oct_val    = {val_reg[4:0], char_in[2:0]};
        hex_val    = {val_reg[3:0], hex[3:0]};
        cnt_inc    = cnt_reg + 2'd1;
        is_oct     = (char_in >= CH_ZERO) && (char_in <= CH_SEVEN);

        unique case (req_type)
            REQ_TEXT:
            begin
                if (!stop_reg)
                begin
                    if (space_reg)
                    begin
                        pb[n[0]] = CH_SPACE;
                        n = n + 2'd1;
                        space_next = 1'b0;
                    end
                    if (!escape_enable)
                    begin
                        if (flush_due)
                        begin
                            pb[n[0]] = flush_byte;
                            n = n + 2'd1;
                        end
                        mode_next = MODE_PLAIN;
                        cnt_next  = 2'd0;
                        val_next  = 8'd0;
                        pb[n[0]] = char_in;
                        n = n + 2'd1;
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_PLAIN:
                            begin
                                if (char_in == CH_BACKSLASH)
                                    mode_next = MODE_BSL;
                                else
                                begin
                                    pb[n[0]] = char_in;
                                    n = n + 2'd1;
                                end
                            end
                            MODE_BSL:
                            begin
                                mode_next = MODE_PLAIN;
                                if (code[8])
                                begin
                                    pb[n[0]] = code[7:0];
                                    n = n + 2'd1;
                                end
                                else if (char_in == CH_C)
                                    stop_next = 1'b1;
                                else if (char_in == CH_ZERO)
                                begin
                                    mode_next = MODE_OCT;
                                    cnt_next  = 2'd0;
                                    val_next  = 8'd0;
                                end
                                else if (char_in == CH_X)
                                begin
                                    mode_next = MODE_HEX;
                                    cnt_next  = 2'd0;
                                    val_next  = 8'd0;
                                end
                                else
                                begin
                                    pb[n[0]] = CH_BACKSLASH;
                                    n = n + 2'd1;
                                    pb[n[0]] = char_in;
                                    n = n + 2'd1;
                                end
                            end
                            MODE_OCT, MODE_HEX:
                            begin
                                if (mode_reg == MODE_OCT && is_oct)
                                begin
                                    val_next = oct_val;
                                    cnt_next = cnt_inc;
                                    if (cnt_inc == 2'd3)
                                    begin
                                        pb[n[0]] = oct_val;
                                        n = n + 2'd1;
                                        mode_next = MODE_PLAIN;
                                        cnt_next  = 2'd0;
                                        val_next  = 8'd0;
                                    end
                                end
                                else if (mode_reg == MODE_HEX && hex[4])
                                begin
                                    val_next = hex_val;
                                    cnt_next = cnt_inc;
                                    if (cnt_inc == 2'd2)
                                    begin
                                        pb[n[0]] = hex_val;
                                        n = n + 2'd1;
                                        mode_next = MODE_PLAIN;
                                        cnt_next  = 2'd0;
                                        val_next  = 8'd0;
                                    end
                                end
                                else
                                begin
                                    // early end: emit collected value, then decode as plain
                                    pb[n[0]] = val_reg;
                                    n = n + 2'd1;
                                    mode_next = MODE_PLAIN;
                                    cnt_next  = 2'd0;
                                    val_next  = 8'd0;
                                    if (char_in == CH_BACKSLASH)
                                        mode_next = MODE_BSL;
                                    else
                                    begin
                                        pb[n[0]] = char_in;
                                        n = n + 2'd1;
                                    end
                                end
                            end
                            default:
                            begin
                                mode_next = MODE_PLAIN;
                                cnt_next  = 2'd0;
                                val_next  = 8'd0;
                            end
                        endcase
                    end
                end
            end
            REQ_ARG_END:
            begin
                if (!stop_reg)
                begin
                    if (space_reg)
                    begin
                        pb[n[0]] = CH_SPACE;
                        n = n + 2'd1;
                    end
                    if (flush_due)
                    begin
                        pb[n[0]] = flush_byte;
                        n = n + 2'd1;
                    end
                    mode_next  = MODE_PLAIN;
                    cnt_next   = 2'd0;
                    val_next   = 8'd0;
                    space_next = 1'b1;
                end
            end
            REQ_CMD_END:
            begin
                if (!stop_reg)
                begin
                    if (flush_due)
                    begin
                        pb[n[0]] = flush_byte;
                        n = n + 2'd1;
                    end
                    if (trailing_newline)
                    begin
                        pb[n[0]] = CH_NEWLINE;
                        n = n + 2'd1;
                    end
                end
                if (n == 2'd0)
                begin
                    no_byte = 1'b1;
                    n = 2'd1;
                end
                done_f     = 1'b1;
                mode_next  = MODE_PLAIN;
                cnt_next   = 2'd0;
                val_next   = 8'd0;
                space_next = 1'b0;
                stop_next  = 1'b0;
            end
            default:
            begin
                n = 2'd0;
            end
        endcase
    end

    assign dec.count               = fire ? n : 2'd0;
    assign dec.first.byte_out      = pb[0];
    assign dec.first.byte_valid    = !no_byte;
    assign dec.first.last          = (n == 2'd1);
    assign dec.first.command_done  = done_f && (n == 2'd1);
    assign dec.second.byte_out     = pb[1];
    assign dec.second.byte_valid   = 1'b1;
    assign dec.second.last         = 1'b1;
    assign dec.second.command_done = done_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            cnt_reg   <= 2'd0;
            val_reg   <= 8'd0;
            space_reg <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            val_reg   <= val_next;
            space_reg <= space_next;
            stop_reg  <= stop_next;
        end
    end

endmodule : bed_decoder

`default_nettype wire

>>> src/backslash_escape_decoder.sv
// Top level: config registers, escape decoder and output result queue.
//
// Input channel (in_valid/in_ready) carries one transaction per item:
// req_type selects text byte, end of argument or end of command, char_in
// holds the byte. Output channel (out_valid/out_ready) carries decoded
// results: byte_out, byte_valid, last (final result of one input) and
// command_done (final result of an end of command).
// Each input yields zero, one or two results. Decoding is done in the
// accept cycle and the results land in a 4-entry queue; the first result
// is visible on the output in the cycle after acceptance if the queue was empty.
// Throughput: one input per cycle while each yields at most one result
// and the receiver takes one result per cycle; the output side moves one
// result per cycle, so two-result inputs set the sustained rate.
// in_ready is high while the queue has room for two results; when the
// receiver stalls the queue fills and in_ready drops, nothing is lost.
// Reset clears the queue and decode state; escape_enable resets to 0,
// trailing_newline to 1. Registers sit at APB byte addresses 0 and 4.
`default_nettype none

module backslash_escape_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  char_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       byte_out,
    output logic             byte_valid,
    output logic             last,
    output logic             command_done,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bed_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    logic             esc_en_reg;
    logic             newline_reg;
    logic             cfg_wr;
    logic             fire;
    logic             pop;
    dec_out_t         dec;
    result_t          queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] wp_inc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == 1'(REG_TRAILING_NEWLINE)) ? {31'd0, newline_reg}
                                                           : {31'd0, esc_en_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_en_reg  <= 1'b0;
            newline_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == 1'(REG_ESCAPE_ENABLE))
                esc_en_reg <= pwdata[0];
            else
                newline_reg <= pwdata[0];
        end
    end

    assign in_ready = (cnt_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign fire     = in_valid && in_ready;
    assign out_valid = (cnt_reg != '0);
    assign pop      = out_valid && out_ready;

    bed_decoder u_decoder (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .req_type         (req_type),
        .char_in          (char_in),
        .escape_enable    (esc_en_reg),
        .trailing_newline (newline_reg),
        .dec              (dec)
    );

    assign wp_inc   = wp_reg + PTR_W'(1);
    assign cnt_next = cnt_reg + CNT_W'(dec.count) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (dec.count != 2'd0)
            queue_reg[wp_reg] <= dec.first;
        if (dec.count == 2'd2)
            queue_reg[wp_inc] <= dec.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + PTR_W'(dec.count);
            cnt_reg <= cnt_next;
            if (pop)
                rp_reg <= rp_reg + PTR_W'(1);
        end
    end

    assign byte_out     = queue_reg[rp_reg].byte_out;
    assign byte_valid   = queue_reg[rp_reg].byte_valid;
    assign last         = queue_reg[rp_reg].last;
    assign command_done = queue_reg[rp_reg].command_done;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_cmd_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req_type == REQ_CMD_END) |=> cnt_reg != '0)
        else $error("end of command produced no result");

    a_ignored_req: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req_type == REQ_NONE) |=> cnt_reg <= $past(cnt_reg))
        else $error("ignored request produced a result");

    a_cmd_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_done |-> last)
        else $error("command_done without last");

endmodule : backslash_escape_decoder

`default_nettype wire

>>> verif/tb_top.sv
// Testbench for the backslash escape decoder: directed and random commands checked by a scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bed_pkg::*;

    localparam logic [7:0] CH_BELL      = 8'h07;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_VTAB      = 8'h0B;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_ESCAPE    = 8'h1B;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int NUM_PHASES   = 8;
    localparam logic [0:NUM_PHASES-1] ESC_PLAN = 8'b1100_1011;
    localparam logic [0:NUM_PHASES-1] NL_PLAN  = 8'b1010_0111;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_BACKSLASH,
        MODE_OCTAL,
        MODE_HEX
    } esc_mode_t;

    class escape_scoreboard;
        bit         escapes_on;
        bit         newline_on;
        esc_mode_t  mode;
        logic [1:0] digits;
        logic [7:0] value;
        bit         space_due;
        bit         muted;
        result_t    expected_bytes[$];
        result_t    produced[$];
        int         errors;

        function new();
            escapes_on = 1'b0;
            newline_on = 1'b1;
            clear_escape();
            space_due = 1'b0;
            muted = 1'b0;
            errors = 0;
        endfunction

        function void clear_escape();
            mode = MODE_PLAIN;
            digits = '0;
            value = '0;
        endfunction

        function void emit(logic [7:0] b, bit shown = 1'b1);
            result_t r;
            r.byte_out = b;
            r.byte_valid = shown;
            r.last = 1'b0;
            r.command_done = 1'b0;
            produced.push_back(r);
        endfunction

        // an open escape prints what it holds so far
        function void flush_escape();
            if (mode == MODE_BACKSLASH)
                emit(CH_BACKSLASH);
            else if (mode != MODE_PLAIN)
                emit(value);
            clear_escape();
        endfunction

        function void plain_char(logic [7:0] c);
            if (c == CH_BACKSLASH)
                mode = MODE_BACKSLASH;
            else
                emit(c);
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return c - "0";
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            return -1;
        endfunction

        function void after_backslash(logic [7:0] c);
            mode = MODE_PLAIN;
            case (c)
                "n":  emit(CH_NEWLINE);
                "t":  emit(CH_TAB);
                "\\": emit(CH_BACKSLASH);
                "a":  emit(CH_BELL);
                "b":  emit(CH_BACKSPACE);
                "e":  emit(CH_ESCAPE);
                "f":  emit(CH_FORMFEED);
                "r":  emit(CH_RETURN);
                "v":  emit(CH_VTAB);
                "c":  muted = 1'b1;
                "0":
                begin
                    mode = MODE_OCTAL;
                    digits = '0;
                    value = '0;
                end
                "x":
                begin
                    mode = MODE_HEX;
                    digits = '0;
                    value = '0;
                end
                default:
                begin
                    emit(CH_BACKSLASH);
                    emit(c);
                end
            endcase
        endfunction

        function void decode_text(logic [7:0] c);
            int d;
            if (muted)
                return;
            if (space_due)
            begin
                emit(CH_SPACE);
                space_due = 1'b0;
            end
            if (!escapes_on)
            begin
                flush_escape();
                emit(c);
                return;
            end
            case (mode)
                MODE_PLAIN:     plain_char(c);
                MODE_BACKSLASH: after_backslash(c);
                MODE_OCTAL:
                begin
                    if (c >= "0" && c <= "7")
                    begin
                        value = 8'(value * 8 + (c - "0"));
                        digits++;
                        if (digits == 3)
                            flush_escape();
                    end
                    else
                    begin
                        flush_escape();
                        plain_char(c);
                    end
                end
                default:
                begin
                    d = hex_value(c);
                    if (d >= 0)
                    begin
                        value = 8'(value * 16 + d);
                        digits++;
                        if (digits == 2)
                            flush_escape();
                    end
                    else
                    begin
                        flush_escape();
                        plain_char(c);
                    end
                end
            endcase
        endfunction

        function void note_input(req_t req, logic [7:0] c);
            result_t r;
            produced.delete();
            case (req)
                REQ_TEXT: decode_text(c);
                REQ_ARG_END:
                begin
                    if (!muted)
                    begin
                        if (space_due)
                            emit(CH_SPACE);
                        flush_escape();
                        space_due = 1'b1;
                    end
                end
                REQ_CMD_END:
                begin
                    if (!muted)
                    begin
                        flush_escape();
                        if (newline_on)
                            emit(CH_NEWLINE);
                    end
                    if (produced.size() == 0)
                        emit(8'h00, 1'b0);
                    r = produced.pop_back();
                    r.command_done = 1'b1;
                    produced.push_back(r);
                    clear_escape();
                    space_due = 1'b0;
                    muted = 1'b0;
                end
                default: ;
            endcase
            if (produced.size() > 0)
            begin
                r = produced.pop_back();
                r.last = 1'b1;
                produced.push_back(r);
            end
            foreach (produced[i])
                expected_bytes.push_back(produced[i]);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected transaction: expected none, got byte_out=%h valid=%b last=%b done=%b",
                         $time, got.byte_out, got.byte_valid, got.last, got.command_done);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            compare_field("byte_out", want.byte_out, got.byte_out);
            compare_field("byte_valid", want.byte_valid, got.byte_valid);
            compare_field("last", want.last, got.last);
            compare_field("command_done", want.command_done, got.command_done);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [7:0]  char_in;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  byte_out;
    logic        byte_valid;
    logic        last;
    logic        command_done;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    escape_scoreboard sb;
    bit idle_on;
    int sent_items;
    int quiet_cycles;

    backslash_escape_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .char_in      (char_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_out     (byte_out),
        .byte_valid   (byte_valid),
        .last         (last),
        .command_done (command_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // all tasks start and end on a falling edge
    task automatic send_item(req_t req, logic [7:0] c);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        char_in <= c;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(req, c);
        if (req != REQ_NONE)
            sent_items++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(REQ_TEXT, s[i]);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.expected_bytes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(int unsigned index, logic bit_value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(index * 4);
        pwdata <= 32'(bit_value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (index == REG_ESCAPE_ENABLE)
            sb.escapes_on = bit_value;
        else
            sb.newline_on = bit_value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // mostly well-formed escapes and argument structure, some noise
    task automatic send_random_sequence();
        string named = "ntabefrv\\";
        string hexdigits = "0123456789abcdefABCDEF";
        int pick;
        int k;
        logic [7:0] any;
        pick = $urandom_range(0, 99);
        any = 8'($urandom);
        if (pick < 35)
            send_item(REQ_TEXT, $urandom_range(0, 1) ? any : 8'($urandom_range("a", "z")));
        else if (pick < 50)
        begin
            send_item(REQ_TEXT, CH_BACKSLASH);
            send_item(REQ_TEXT, named[$urandom_range(0, named.len() - 1)]);
        end
        else if (pick < 60)
        begin
            send_text("\\0");
            k = $urandom_range(0, 3);
            repeat (k) send_item(REQ_TEXT, 8'($urandom_range("0", "7")));
        end
        else if (pick < 70)
        begin
            send_text("\\x");
            k = $urandom_range(0, 2);
            repeat (k) send_item(REQ_TEXT, hexdigits[$urandom_range(0, hexdigits.len() - 1)]);
        end
        else if (pick < 74)
        begin
            send_item(REQ_TEXT, CH_BACKSLASH);
            send_item(REQ_TEXT, any);
        end
        else if (pick < 76)
            send_text("\\c");
        else if (pick < 88)
            send_item(REQ_ARG_END, any);
        else if (pick < 95)
            send_item(REQ_CMD_END, any);
        else if (pick < 97)
            send_item(REQ_NONE, any);
        else
            send_item(req_t'($urandom_range(0, 3)), any);
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0 && idle_on)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 16);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_t'({byte_out, byte_valid, last, command_done}));
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int target;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_TEXT;
        char_in = 8'h00;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_on = 1'b1;
        sent_items = 0;
        quiet_cycles = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apb_write(REG_ESCAPE_ENABLE, 1'b1);
        apb_write(REG_TRAILING_NEWLINE, 1'b1);

        // byte extremes, empty argument, unknown escape, octal overflow,
        // hex without digits, trailing backslash, ignored request, \c
        send_item(REQ_TEXT, 8'h00);
        send_item(REQ_TEXT, 8'hFF);
        send_item(REQ_ARG_END, 8'h00);
        send_item(REQ_ARG_END, 8'hFF);
        send_text("\\q");
        send_text("\\0777");
        send_text("\\xg");
        send_text("\\");
        send_item(REQ_ARG_END, 8'h00);
        send_item(REQ_NONE, 8'hA5);
        send_text("\\ca");
        send_item(REQ_CMD_END, 8'h00);
        // numeric escape still open at end of command
        send_text("\\x4");
        send_item(REQ_CMD_END, 8'h00);
        wait_for_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            apb_write(REG_ESCAPE_ENABLE, ESC_PLAN[p]);
            apb_write(REG_TRAILING_NEWLINE, NL_PLAN[p]);
            idle_on = (p != NUM_PHASES - 1);
            target = sent_items + RANDOM_ITEMS / NUM_PHASES;
            while (sent_items < target)
                send_random_sequence();
            // leave an escape open across the register change
            if ($urandom_range(0, 1))
            begin
                send_item(REQ_TEXT, CH_BACKSLASH);
                if ($urandom_range(0, 1))
                    send_item(REQ_TEXT, $urandom_range(0, 1) ? "x" : "0");
            end
            wait_for_results();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_bytes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> files.f
src/bed_pkg.sv
src/bed_decoder.sv
src/backslash_escape_decoder.sv
verif/tb_top.sv
